@@ hw/rtl/tlb_pkg.sv @@
// ----------------------------------------------------------------------------
// tlb package
// shared types and constants of the translation buffer
// ----------------------------------------------------------------------------
package tlb_pkg;

    localparam int unsigned PidW   = 32;
    localparam int unsigned PageW  = 32;
    localparam int unsigned FrameW = 20;
    localparam int unsigned AddrW  = 32;
    localparam int unsigned StampW = 32;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CfgPolicy = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgLimit  = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgShift  = 2'd2;

    typedef enum logic {
        ACT_TRANSLATE = 1'b0,
        ACT_FILL      = 1'b1
    } t_action;

    // search token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [FrameW-1:0] frame;
    } t_search;

    // victim token: smallest stamp among the used cells passed so far
    typedef struct packed {
        logic              valid;
        logic [StampW-1:0] stamp;
    } t_victim;

endpackage

@@ hw/rtl/tlb_cell.sv @@
// ----------------------------------------------------------------------------
// tlb cell
// one entry: tag, frame and stamps, compares and forwards the tokens
// ----------------------------------------------------------------------------
module tlb_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_used,
    input  logic [tlb_pkg::PidW-1:0]  i_pid,
    input  logic [tlb_pkg::PageW-1:0] i_page,
    input  logic                    i_policy_lru,
    input  logic [tlb_pkg::StampW-1:0] i_time,
    input  logic                    i_match_en,
    input  logic                    i_touch,
    input  logic                    i_write,
    input  logic [tlb_pkg::FrameW-1:0] i_wr_frame,
    input  tlb_pkg::t_search        i_search,
    output tlb_pkg::t_search        o_search,
    output logic                    o_hit_here,
    input  tlb_pkg::t_victim        i_victim,
    output tlb_pkg::t_victim        o_victim,
    output logic                    o_better
);
    import tlb_pkg::*;

    logic [PidW-1:0]   r_pid;
    logic [PageW-1:0]  r_page;
    logic [FrameW-1:0] r_frame;
    logic [StampW-1:0] r_birth;
    logic [StampW-1:0] r_use;
    logic              match;
    logic [StampW-1:0] key;

    assign match      = i_used && i_match_en && r_pid == i_pid && r_page == i_page;
    assign o_hit_here = match && !i_search.found;
    assign key        = i_policy_lru ? r_use : r_birth;
    // strict compare keeps the lowest index on a tie
    assign o_better   = i_used && (!i_victim.valid || key < i_victim.stamp);

    always_ff @(posedge i_clk) begin
        o_search.valid <= i_rst_n && i_search.valid;
        o_search.found <= i_search.found || match;
        o_search.frame <= i_search.found ? i_search.frame : (match ? r_frame : '0);
        o_victim.valid <= i_rst_n && (i_victim.valid || o_better);
        o_victim.stamp <= o_better ? key : i_victim.stamp;
        if (i_write) begin
            r_pid   <= i_pid;
            r_page  <= i_page;
            r_frame <= i_wr_frame;
            r_birth <= i_time;
            r_use   <= i_time;
        end else if (i_touch) begin
            r_use <= i_time;
        end
    end

endmodule

@@ hw/rtl/tlb_translate_fifo_lru.sv @@
// ----------------------------------------------------------------------------
// tlb translate fifo lru
// fully associative tlb tagged by process id and page
// ----------------------------------------------------------------------------
// Entries sit in a row of cells; a request's search and victim tokens pass one
// cell per cycle, through the scan and done states to the result strobe (fills
// give no strobe); busy is high meanwhile, and the next request is taken only
// once the previous one is through. Results are shown for one cycle and cannot
// be stalled.
module tlb_translate_fifo_lru #(
    parameter int unsigned MAX_ENTRIES = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_action,
    input  logic [tlb_pkg::PidW-1:0]        i_process_id,
    input  logic [tlb_pkg::AddrW-1:0]       i_logical_address,
    input  logic [tlb_pkg::PageW-1:0]       i_fill_page,
    input  logic [tlb_pkg::FrameW-1:0]      i_fill_frame,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tlb_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    output logic                            o_valid,
    output logic                            o_hit,
    output logic [tlb_pkg::PageW-1:0]       o_page_number,
    output logic [tlb_pkg::FrameW-1:0]      o_frame_number,
    output logic [tlb_pkg::AddrW-1:0]       o_physical_address
);
    import tlb_pkg::*;

    localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned StepW = $clog2(MAX_ENTRIES + 2);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state            r_state;
    logic [StepW-1:0]  r_step;
    logic              r_policy;
    logic [5:0]        r_limit;
    logic [4:0]        r_shift;
    logic [CntW-1:0]   r_filled;
    logic [StampW-1:0] r_time;
    t_action           r_act;
    logic [PidW-1:0]   r_pid;
    logic [PageW-1:0]  r_page;
    logic [AddrW-1:0]  r_offset;
    logic [FrameW-1:0] r_fframe;
    logic [IdxW-1:0]   r_victim;

    t_search search [MAX_ENTRIES+1];
    t_victim victim [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] hit_here, better, wr_sel;

    logic [CntW-1:0] eff_limit;
    logic            append;
    logic [AddrW-1:0] laddr_page;

    assign busy        = r_state != S_IDLE;
    assign o_cfg_ready = r_state == S_IDLE;
    assign laddr_page  = i_logical_address >> r_shift;

    always_comb begin
        if (r_limit == 6'd0) eff_limit = CntW'(1);
        else if (32'(r_limit) > MAX_ENTRIES) eff_limit = CntW'(MAX_ENTRIES);
        else eff_limit = CntW'(r_limit);
    end
    assign append = r_filled < eff_limit;

    assign search[0] = '{valid: r_state == S_SCAN && r_step == '0, found: 1'b0,
                         frame: '0};
    assign victim[0] = '{valid: 1'b0, stamp: '0};

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic used;
        logic en;
        assign used = CntW'(g) < r_filled;
        assign en   = r_state == S_SCAN && r_step == StepW'(g);
        assign wr_sel[g] = r_state == S_DONE && r_act == ACT_FILL &&
                           (append ? r_filled == CntW'(g) : r_victim == IdxW'(g));
        tlb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_used      (used),
            .i_pid       (r_pid),
            .i_page      (r_page),
            .i_policy_lru(r_policy),
            .i_time      (r_time),
            .i_match_en  (en && r_act == ACT_TRANSLATE),
            .i_touch     (en && r_act == ACT_TRANSLATE && r_policy &&
                          hit_here[g]),
            .i_write     (wr_sel[g]),
            .i_wr_frame  (r_fframe),
            .i_search    (search[g]),
            .o_search    (search[g+1]),
            .o_hit_here  (hit_here[g]),
            .i_victim    (victim[g]),
            .o_victim    (victim[g+1]),
            .o_better    (better[g])
        );
    end

    logic [AddrW-1:0] phys;
    assign phys = (AddrW'(search[MAX_ENTRIES].frame) << r_shift) + r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_policy <= 1'b0;
            r_limit  <= 6'd32;
            r_shift  <= 5'd5;
            r_filled <= '0;
            r_time   <= '0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CfgPolicy: r_policy <= i_cfg_data[0];
                    CfgLimit:  r_limit  <= i_cfg_data[5:0];
                    CfgShift:  r_shift  <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state  <= S_SCAN;
                        r_step   <= '0;
                        r_act    <= t_action'(i_action);
                        r_pid    <= i_process_id;
                        r_page   <= (i_action == ACT_FILL) ? i_fill_page : laddr_page;
                        r_offset <= i_logical_address &
                                    ~({AddrW{1'b1}} << r_shift);
                        r_fframe <= i_fill_frame;
                        r_victim <= '0;
                    end
                end
                S_SCAN: begin
                    // victim index follows the token: cell step is the one compared
                    if (better[r_step[IdxW-1:0]] &&
                        32'(r_step) < MAX_ENTRIES) begin
                        r_victim <= r_step[IdxW-1:0];
                    end
                    if (r_act == ACT_TRANSLATE && r_policy &&
                        32'(r_step) < MAX_ENTRIES && hit_here[r_step[IdxW-1:0]]) begin
                        r_time <= r_time + 1'b1;
                    end
                    r_step <= r_step + 1'b1;
                    // the last cell's token is at the row end in the next cycle
                    if (32'(r_step) == MAX_ENTRIES - 1) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                    if (r_act == ACT_FILL) begin
                        r_time <= r_time + 1'b1;
                        if (append) r_filled <= r_filled + 1'b1;
                    end else begin
                        o_valid            <= 1'b1;
                        o_hit              <= search[MAX_ENTRIES].found;
                        o_page_number      <= r_page;
                        o_frame_number     <= search[MAX_ENTRIES].frame;
                        o_physical_address <= search[MAX_ENTRIES].found ? phys : '0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_fill_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_act == ACT_FILL) |=> !o_valid)
        else $error("fill produced a result");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(wr_sel))
        else $error("more than one entry written");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_filled) <= MAX_ENTRIES)
        else $error("fill count beyond capacity");
`endif

endmodule
